### rtl/kdar_pkg.sv
// Shared types and constants for the key debounce / auto-repeat block.
// No dependencies; the interfaces, kdar_key_update and the top import this package.
package kdar_pkg;

    localparam int TICK_W    = 8;
    localparam int MODE_W    = 4;
    localparam int KEY_W     = 4;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KILL   = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] EV_REPEAT = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG   = 2'd2;
    localparam logic [KIND_W-1:0] EV_BREAK  = 2'd3;

    // Per-key mode codes; repeat modes are 8 + log2(interval)
    localparam logic [MODE_W-1:0] MODE_OFF    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_START  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DELAY  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PAUSE  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_KILLED = 4'd4;
    localparam logic [MODE_W-1:0] MODE_RPT0   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_RPT1   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_RPT2   = 4'd10;
    localparam logic [MODE_W-1:0] MODE_RPT3   = 4'd11;
    localparam logic [MODE_W-1:0] MODE_RPT4   = 4'd12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE        = 2'd3;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 8'd32;
    localparam logic [CFG_W-1:0] FIRST_REPEAT_RST = 8'd40;
    localparam logic [CFG_W-1:0] REPEAT_STEP_RST  = 8'd48;
    localparam logic [CFG_W-1:0] PAUSE_RST        = 8'd64;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] first_repeat_ticks;
        logic [CFG_W-1:0] repeat_step_ticks;
        logic [CFG_W-1:0] pause_ticks;
    } kdar_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
    } kdar_event_t;

endpackage

### rtl/kdar_in_if.sv
// Input channel of the key debounce block: valid/ready plus one item.
// Depends on kdar_pkg for field widths.
interface kdar_in_if;
    import kdar_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_index;
    logic             key_level;

    modport source (output valid, output cmd, output key_index, output key_level,
                    input ready);
    modport sink   (input valid, input cmd, input key_index, input key_level,
                    output ready);
endinterface

### rtl/kdar_out_if.sv
// Result channel of the key debounce block: valid/ready plus one result.
// Depends on kdar_pkg for field widths.
interface kdar_out_if;
    import kdar_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key_out;
    logic              event_valid;
    logic [KIND_W-1:0] event_kind;
    logic              key_pressed;

    modport source (output valid, output key_out, output event_valid,
                    output event_kind, output key_pressed, input ready);
    modport sink   (input valid, input key_out, input event_valid,
                    input event_kind, input key_pressed, output ready);
endinterface

### rtl/kdar_state_ram.sv
// Per-key state memory: one write port, one registered read port,
// per-entry valid bits (unwritten entries read as zero) and a write bypass.
module kdar_state_ram #(
    parameter  int DEPTH = 16,
    parameter  int WIDTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] mem_q_reg;
    logic             vld_q_reg;
    logic             hit_reg;
    logic [WIDTH-1:0] byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
            byp_reg   <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[rd_addr];
                // same-edge write to the entry being read: take the new data
                hit_reg   <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = hit_reg   ? byp_reg   :
                     vld_q_reg ? mem_q_reg : '0;

    a_hit_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && wr_en && (wr_addr == rd_addr) |=> hit_reg && (rd_data == $past(wr_data)))
        else $error("bypass did not forward the same-edge write");

    a_unwritten_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && !wr_en && !vld_reg[rd_addr] |=> (rd_data == '0))
        else $error("unwritten entry did not read as zero");

    a_written_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(wr_addr)])
        else $error("written entry not marked valid");

endmodule

### rtl/kdar_key_update.sv
// Next-state and event logic for one key item (filter, tick counter, mode).
// Depends on kdar_pkg; pure combinational update of one memory entry.
module kdar_key_update #(
    parameter  int FILTER_DEPTH = 4,
    localparam int EW           = FILTER_DEPTH + kdar_pkg::TICK_W + kdar_pkg::MODE_W
) (
    input  logic [kdar_pkg::CMD_W-1:0] cmd,
    input  logic                       key_level,
    input  logic                       in_range,
    input  kdar_pkg::kdar_cfg_t        cfg,
    input  logic [EW-1:0]              cur_entry,
    output logic [EW-1:0]              nxt_entry,
    output kdar_pkg::kdar_event_t      ev,
    output logic                       pressed
);
    import kdar_pkg::*;

    localparam logic [FILTER_DEPTH-1:0] FILT_ONES = '1;

    logic [FILTER_DEPTH-1:0] cur_filt;
    logic [TICK_W-1:0]       cur_tick;
    logic [MODE_W-1:0]       cur_mode;
    logic [FILTER_DEPTH:0]   filt_shift;
    logic [FILTER_DEPTH-1:0] f;
    logic [TICK_W-1:0]       cnt;
    logic [MODE_W-1:0]       m;
    logic [TICK_W-1:0]       rpt_mask;
    kdar_event_t             ev_raw;

    assign {cur_mode, cur_tick, cur_filt} = cur_entry;
    assign filt_shift = {cur_filt, key_level};

    always_comb
    begin
        f        = cur_filt;
        cnt      = cur_tick;
        m        = cur_mode;
        ev_raw   = '0;
        rpt_mask = '0;
        case (cmd)
            CMD_SAMPLE:
            begin
                f   = filt_shift[FILTER_DEPTH-1:0];
                cnt = cur_tick + TICK_W'(1);
                // release ends any press
                if ((m != MODE_OFF) && (f == '0))
                begin
                    if (m != MODE_KILLED)
                    begin
                        ev_raw.valid = 1'b1;
                        ev_raw.kind  = EV_BREAK;
                    end
                    cnt = '0;
                    m   = MODE_OFF;
                end
                case (m)
                    MODE_OFF:
                    begin
                        if (f == FILT_ONES)
                        begin
                            m   = MODE_START;
                            cnt = '0;
                        end
                    end
                    MODE_START:
                    begin
                        ev_raw.valid = 1'b1;
                        ev_raw.kind  = EV_FIRST;
                        m            = MODE_DELAY;
                        cnt          = '0;
                    end
                    MODE_DELAY:
                    begin
                        if (cnt == cfg.long_press_ticks)
                        begin
                            ev_raw.valid = 1'b1;
                            ev_raw.kind  = EV_LONG;
                        end
                        if (cnt == cfg.first_repeat_ticks)
                        begin
                            m   = MODE_RPT4;
                            cnt = '0;
                        end
                    end
                    MODE_PAUSE:
                    begin
                        if (cnt >= cfg.pause_ticks)
                        begin
                            m   = MODE_RPT3;
                            cnt = '0;
                        end
                    end
                    MODE_RPT4, MODE_RPT3, MODE_RPT2, MODE_RPT1:
                    begin
                        // halve the interval once the step has elapsed
                        if (cnt >= cfg.repeat_step_ticks)
                        begin
                            m   = m - MODE_W'(1);
                            cnt = '0;
                        end
                        rpt_mask = ~({TICK_W{1'b1}} << m[2:0]);
                        if ((cnt & rpt_mask) == '0)
                        begin
                            ev_raw.valid = 1'b1;
                            ev_raw.kind  = EV_REPEAT;
                        end
                    end
                    MODE_RPT0:
                    begin
                        ev_raw.valid = 1'b1;
                        ev_raw.kind  = EV_REPEAT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_PAUSE:
            begin
                m   = MODE_PAUSE;
                cnt = '0;
            end
            CMD_KILL:
            begin
                m = MODE_KILLED;
            end
            default:
            begin
            end
        endcase
    end

    assign nxt_entry = {m, cnt, f};
    assign ev        = in_range ? ev_raw : '0;
    assign pressed   = in_range && (f == FILT_ONES);

endmodule

### rtl/key_debounce_auto_repeat_top.sv
// Top level of the key debounce and accelerating auto-repeat block.
// Depends on kdar_pkg, kdar_in_if, kdar_out_if, kdar_state_ram, kdar_key_update.

// Debounces a bank of NUM_KEYS_P keys and turns each key's sample stream into
// first-press, long-press, repeat and break events. Items arrive one per beat
// on in_ch, each naming one key; every item yields exactly one result beat on
// out_ch, in order. The block takes one item per clock cycle sustained while
// out_ch is ready; a stalled output holds the input. The per-key state
// (filter, tick counter, mode) lives in a single memory read at acceptance and
// written back when the item leaves the update stage; the one read-modify-write
// per item per cycle, closed by a write bypass in the memory, sets that rate.
// Back-to-back items for the same key are handled at full rate. Reset returns
// every key to the off state at once (no clearing pass) and loads the register
// defaults 32, 40, 48 and 64. Write the configuration registers only while no
// item is in flight.
module key_debounce_auto_repeat_top #(
    parameter int NUM_KEYS_P   = 16,
    parameter int FILTER_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    kdar_in_if.sink                        in_ch,
    kdar_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [kdar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kdar_pkg::CFG_W-1:0]     cfg_data
);
    import kdar_pkg::*;

    localparam int AW = (NUM_KEYS_P > 1) ? $clog2(NUM_KEYS_P) : 1;
    localparam int EW = FILTER_DEPTH + TICK_W + MODE_W;

    // Configuration registers
    kdar_cfg_t cfg_reg;

    // Update stage: holds the item whose state is being read this cycle
    logic             s1_valid_reg;
    logic [CMD_W-1:0] s1_cmd_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic             s1_level_reg;

    // Output register
    logic              out_valid_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic              out_ev_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_pressed_reg;

    logic              in_fire;
    logic              s1_fire;
    logic              s1_in_range;
    logic [KEY_W+AW-1:0] in_key_ext;
    logic [KEY_W+AW-1:0] s1_key_ext;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     cur_entry;
    logic [EW-1:0]     nxt_entry;
    kdar_event_t       ev;
    logic              pressed;

    // Advance the update stage whenever the output register is free or drains
    assign s1_fire     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign in_key_ext  = {{AW{1'b0}}, in_ch.key_index};
    assign s1_key_ext  = {{AW{1'b0}}, s1_key_reg};
    assign rd_addr     = in_key_ext[AW-1:0];
    assign wr_addr     = s1_key_ext[AW-1:0];
    // Keys beyond the bank change nothing and report not pressed
    assign s1_in_range = ({{(32-KEY_W){1'b0}}, s1_key_reg} < 32'(NUM_KEYS_P));

    kdar_state_ram #(
        .DEPTH (NUM_KEYS_P),
        .WIDTH (EW)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (cur_entry),
        .wr_en   (s1_fire && s1_in_range),
        .wr_addr (wr_addr),
        .wr_data (nxt_entry)
    );

    kdar_key_update #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_key_update (
        .cmd       (s1_cmd_reg),
        .key_level (s1_level_reg),
        .in_range  (s1_in_range),
        .cfg       (cfg_reg),
        .cur_entry (cur_entry),
        .nxt_entry (nxt_entry),
        .ev        (ev),
        .pressed   (pressed)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks   <= LONG_PRESS_RST;
            cfg_reg.first_repeat_ticks <= FIRST_REPEAT_RST;
            cfg_reg.repeat_step_ticks  <= REPEAT_STEP_RST;
            cfg_reg.pause_ticks        <= PAUSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:   cfg_reg.long_press_ticks   <= cfg_data;
                CFG_FIRST_REPEAT: cfg_reg.first_repeat_ticks <= cfg_data;
                CFG_REPEAT_STEP:  cfg_reg.repeat_step_ticks  <= cfg_data;
                CFG_PAUSE:        cfg_reg.pause_ticks        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Stage and output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the accepted beat, then hold the result until taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg   <= in_ch.cmd;
            s1_key_reg   <= in_ch.key_index;
            s1_level_reg <= in_ch.key_level;
        end
        if (s1_fire)
        begin
            out_key_reg      <= s1_key_reg;
            out_ev_valid_reg <= ev.valid;
            out_kind_reg     <= ev.kind;
            out_pressed_reg  <= pressed;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.key_out     = out_key_reg;
    assign out_ch.event_valid = out_ev_valid_reg;
    assign out_ch.event_kind  = out_kind_reg;
    assign out_ch.key_pressed = out_pressed_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && out_valid_reg && !out_ch.ready)
        else $error("input stalled while the pipeline has room");

    a_break_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ev_valid_reg && (out_kind_reg == EV_BREAK)
        |-> !out_pressed_reg)
        else $error("break event reported with key still pressed");

    a_no_event_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ev_valid_reg |-> (out_kind_reg == EV_FIRST))
        else $error("event kind set without an event");

endmodule
